FILE: hw/rtl/fyrs_pkg.sv
`default_nettype none

package fyrs_pkg;

    // Default row store depth.
    localparam int DEF_MAX_LENGTH = 16;

    // Fixed field widths.
    localparam int WORD_W = 32;
    localparam int ELEM_W = 4;
    localparam int CFG_W  = 5;

    // Row length after reset.
    localparam logic [CFG_W-1:0] ROW_LENGTH_RESET = 5'd12;

    // Depth of the step queue between the front and the back.
    localparam int QUEUE_DEPTH = 2;

    // Sequencer of the back part.
    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV,
        S_RD_I,
        S_RD_J,
        S_WR_I,
        S_WR_J,
        S_EM_RD,
        S_EM_LD
    } t_back_state;

endpackage

`default_nettype wire

FILE: hw/rtl/fisher_yates_row_shuffle.sv
`default_nettype none

// Fisher-Yates row shuffle. The block builds random permutations of
// 0..L-1, where L is the row length register clamped to the range 2 to
// MAX_LENGTH. Each input item carries one random word and performs one swap
// step: for the current position i, counting down from L-1 to 1, it takes
// j = word mod (i+1) and swaps entries i and j of the row store. The item
// that performs the swap at position 1 finishes the row, and the block then
// emits L result items, one per element in row order, with last_of_row set on
// the final one; the store then returns to the identity. Every other item
// produces no result. Writing the row length drops any row in progress and
// restarts from the identity; the write must happen while the block is idle.
// A front section tags each item with its swap position and places it in a
// two-entry queue, so the input keeps accepting until the queue is full while
// the back section works. The back section finishes each step before it takes
// the next from the queue: it waits on the bit-serial remainder unit while
// that works through the dividend and hands over the result, then performs
// the swap through the single read port of the row store, reading entries i
// and j and writing them back exchanged. A finishing step then emits the row,
// each element being read from that same port before it is loaded into the
// output register. The input is stalled for one cycle after reset and after
// each row length write while the store and the swap position are restarted.
module fisher_yates_row_shuffle #(
    parameter int MAX_LENGTH = fyrs_pkg::DEF_MAX_LENGTH
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_in_valid,
    output logic                               o_in_stall,
    input  wire logic [fyrs_pkg::WORD_W-1:0]   i_random_word,
    output logic                               o_out_valid,
    input  wire logic                          i_out_stall,
    output logic      [fyrs_pkg::ELEM_W-1:0]   o_row_element,
    output logic                               o_last_of_row,
    input  wire logic                          i_cfg_valid,
    output logic                               o_cfg_ready,
    input  wire logic [fyrs_pkg::CFG_W-1:0]    i_cfg_row_length
);

    localparam int WW   = fyrs_pkg::WORD_W;
    localparam int PW   = $clog2(MAX_LENGTH);
    localparam int LW   = $clog2(MAX_LENGTH + 1);
    localparam int CW   = (LW > fyrs_pkg::CFG_W) ? LW : fyrs_pkg::CFG_W;
    localparam int QW   = WW + PW + 1;

    // Configuration register and the restart pulse, which is registered from a
    // write and set by reset, so that it comes once the new length is in place.
    logic [fyrs_pkg::CFG_W-1:0] r_row_length;
    logic                       r_restart;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_length <= fyrs_pkg::ROW_LENGTH_RESET;
            r_restart    <= 1'b1;
        end else begin
            r_restart <= i_cfg_valid;
            if (i_cfg_valid) begin
                r_row_length <= i_cfg_row_length;
            end
        end
    end

    assign o_cfg_ready = 1'b1;

    // Effective length minus one: the first swap position and the index of
    // the last emitted element.
    logic [CW-1:0] len_ext;
    logic [CW-1:0] len_eff;
    logic [PW-1:0] last_idx;

    always_comb begin
        len_ext = CW'(r_row_length);
        if (len_ext < CW'(2)) begin
            len_eff = CW'(2);
        end else if (len_ext > CW'(MAX_LENGTH)) begin
            len_eff = CW'(MAX_LENGTH);
        end else begin
            len_eff = len_ext;
        end
        last_idx = PW'(len_eff - CW'(1));
    end

    // Front section.
    logic          push;
    logic [WW-1:0] push_word;
    logic [PW-1:0] push_pos;
    logic          push_last;
    logic          q_full;

    fyrs_front #(
        .PW (PW),
        .WW (WW)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_restart   (r_restart),
        .i_last_idx  (last_idx),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_word      (i_random_word),
        .i_q_full    (q_full),
        .o_push      (push),
        .o_push_word (push_word),
        .o_push_pos  (push_pos),
        .o_push_last (push_last)
    );

    // Step queue.
    logic          pop;
    logic          q_empty;
    logic [QW-1:0] q_data;

    fyrs_queue #(
        .W (QW)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  ({push_word, push_pos, push_last}),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_empty (q_empty),
        .o_data  (q_data)
    );

    // Remainder unit.
    logic          div_start;
    logic [WW-1:0] div_word;
    logic [PW:0]   div_divisor;
    logic          div_done;
    logic [PW:0]   div_rem;

    fyrs_mod #(
        .WW (WW),
        .DW (PW + 1)
    ) u_mod (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (div_start),
        .i_word    (div_word),
        .i_divisor (div_divisor),
        .o_done    (div_done),
        .o_rem     (div_rem)
    );

    // Row store.
    logic          we;
    logic [PW-1:0] waddr;
    logic [PW-1:0] wdata;
    logic          re;
    logic [PW-1:0] raddr;
    logic [PW-1:0] rdata;

    fyrs_ram #(
        .WIDTH (PW),
        .DEPTH (MAX_LENGTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_re    (re),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    // Back section.
    fyrs_back #(
        .MAX_LENGTH (MAX_LENGTH),
        .PW         (PW),
        .WW         (WW)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_restart     (r_restart),
        .i_last_idx    (last_idx),
        .i_q_empty     (q_empty),
        .o_pop         (pop),
        .i_q_word      (q_data[QW-1:PW+1]),
        .i_q_pos       (q_data[PW:1]),
        .i_q_last      (q_data[0]),
        .o_div_start   (div_start),
        .o_div_word    (div_word),
        .o_div_divisor (div_divisor),
        .i_div_done    (div_done),
        .i_div_rem     (div_rem),
        .o_we          (we),
        .o_waddr       (waddr),
        .o_wdata       (wdata),
        .o_re          (re),
        .o_raddr       (raddr),
        .i_rdata       (rdata),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_row_element (o_row_element),
        .o_last_of_row (o_last_of_row)
    );

endmodule

`default_nettype wire

FILE: hw/rtl/fyrs_ram.sv
`default_nettype none

module fyrs_ram #(
    parameter int WIDTH = 4,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

FILE: hw/rtl/fyrs_front.sv
`default_nettype none

// Accepts random words and tags each with its swap position and whether it
// finishes the row.
module fyrs_front #(
    parameter int PW = 4,
    parameter int WW = 32
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_restart,
    input  wire logic [PW-1:0] i_last_idx,
    input  wire logic          i_in_valid,
    output logic               o_in_stall,
    input  wire logic [WW-1:0] i_word,
    input  wire logic          i_q_full,
    output logic               o_push,
    output logic [WW-1:0]      o_push_word,
    output logic [PW-1:0]      o_push_pos,
    output logic               o_push_last
);

    logic [PW-1:0] r_pos;
    logic          is_last;

    assign o_in_stall  = i_q_full | i_restart;
    assign o_push      = i_in_valid & ~o_in_stall;
    assign is_last     = (r_pos == PW'(1));
    assign o_push_word = i_word;
    assign o_push_pos  = r_pos;
    assign o_push_last = is_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
        end else if (i_restart) begin
            r_pos <= i_last_idx;
        end else if (o_push) begin
            r_pos <= is_last ? i_last_idx : r_pos - PW'(1);
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/fyrs_queue.sv
`default_nettype none

// Short first-in first-out queue of tagged steps.
module fyrs_queue #(
    parameter int W = 37
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_push,
    input  wire logic [W-1:0] i_data,
    output logic              o_full,
    input  wire logic         i_pop,
    output logic              o_empty,
    output logic [W-1:0]      o_data
);

    localparam int DEPTH = fyrs_pkg::QUEUE_DEPTH;
    localparam int AW    = $clog2(DEPTH);

    logic [W-1:0]  r_mem [DEPTH];
    logic [AW-1:0] r_wptr;
    logic [AW-1:0] r_rptr;
    logic [AW:0]   r_count;

    assign o_full  = (r_count == (AW+1)'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= r_wptr + AW'(1);
            end
            if (i_pop) begin
                r_rptr <= r_rptr + AW'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + (AW+1)'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - (AW+1)'(1);
            end
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/fyrs_mod.sv
`default_nettype none

// Bit-serial remainder unit: one dividend bit per cycle, restoring form.
module fyrs_mod #(
    parameter int WW = 32,
    parameter int DW = 5
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_start,
    input  wire logic [WW-1:0] i_word,
    input  wire logic [DW-1:0] i_divisor,
    output logic               o_done,
    output logic [DW-1:0]      o_rem
);

    localparam int CNTW = $clog2(WW);
    localparam logic [CNTW-1:0] CNT_LAST = CNTW'(WW - 1);

    logic            r_busy;
    logic            r_done;
    logic [CNTW-1:0] r_cnt;
    logic [WW-1:0]   r_word;
    logic [DW-1:0]   r_div;
    logic [DW-1:0]   r_rem;
    logic [DW:0]     trial;
    logic [DW:0]     n_part;

    always_comb begin
        trial  = {r_rem, r_word[WW-1]};
        n_part = (trial >= {1'b0, r_div}) ? trial - {1'b0, r_div} : trial;
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_word <= i_word;
            r_div  <= i_divisor;
            r_rem  <= '0;
        end else if (r_busy) begin
            r_word <= {r_word[WW-2:0], 1'b0};
            r_rem  <= n_part[DW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + CNTW'(1);
                if (r_cnt == CNT_LAST) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule

`default_nettype wire

FILE: hw/rtl/fyrs_back.sv
`default_nettype none

// Carries out the queued steps: remainder, swap in the row store, and the
// emission of a finished row.
module fyrs_back #(
    parameter int MAX_LENGTH = 16,
    parameter int PW = 4,
    parameter int WW = 32
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_restart,
    input  wire logic [PW-1:0]          i_last_idx,
    input  wire logic                   i_q_empty,
    output logic                        o_pop,
    input  wire logic [WW-1:0]          i_q_word,
    input  wire logic [PW-1:0]          i_q_pos,
    input  wire logic                   i_q_last,
    output logic                        o_div_start,
    output logic [WW-1:0]               o_div_word,
    output logic [PW:0]                 o_div_divisor,
    input  wire logic                   i_div_done,
    input  wire logic [PW:0]            i_div_rem,
    output logic                        o_we,
    output logic [PW-1:0]               o_waddr,
    output logic [PW-1:0]               o_wdata,
    output logic                        o_re,
    output logic [PW-1:0]               o_raddr,
    input  wire logic [PW-1:0]          i_rdata,
    output logic                        o_out_valid,
    input  wire logic                   i_out_stall,
    output logic [fyrs_pkg::ELEM_W-1:0] o_row_element,
    output logic                        o_last_of_row
);

    localparam int EW = fyrs_pkg::ELEM_W;

    fyrs_pkg::t_back_state r_state, n_state;

    logic [PW-1:0]         r_pos;
    logic                  r_last;
    logic [PW-1:0]         r_j;
    logic [PW-1:0]         r_val_i;
    logic [PW-1:0]         r_raddr_q;
    logic [PW-1:0]         r_k;
    logic [MAX_LENGTH-1:0] r_vld;
    logic                  r_out_valid;
    logic [EW-1:0]         r_out_elem;
    logic                  r_out_last;

    logic [PW-1:0] rd_val;
    logic          load;
    logic          k_final;

    // Entries never written since the last restart or the end of the last emitted row read as their own index.
    assign rd_val  = r_vld[r_raddr_q] ? i_rdata : r_raddr_q;
    assign load    = ~r_out_valid | ~i_out_stall;
    assign k_final = (r_k == i_last_idx);

    assign o_div_start   = o_pop;
    assign o_div_word    = i_q_word;
    assign o_div_divisor = (PW+1)'(i_q_pos) + (PW+1)'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= fyrs_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_pop   = 1'b0;
        o_re    = 1'b0;
        o_raddr = r_pos;
        o_we    = 1'b0;
        o_waddr = r_pos;
        o_wdata = r_val_i;
        unique case (r_state)
            fyrs_pkg::S_IDLE: begin
                if (!i_q_empty) begin
                    o_pop   = 1'b1;
                    n_state = fyrs_pkg::S_DIV;
                end
            end
            fyrs_pkg::S_DIV: begin
                if (i_div_done) begin
                    n_state = fyrs_pkg::S_RD_I;
                end
            end
            fyrs_pkg::S_RD_I: begin
                o_re    = 1'b1;
                o_raddr = r_pos;
                n_state = fyrs_pkg::S_RD_J;
            end
            fyrs_pkg::S_RD_J: begin
                o_re    = 1'b1;
                o_raddr = r_j;
                n_state = fyrs_pkg::S_WR_I;
            end
            fyrs_pkg::S_WR_I: begin
                o_we    = 1'b1;
                o_waddr = r_pos;
                o_wdata = rd_val;
                n_state = fyrs_pkg::S_WR_J;
            end
            fyrs_pkg::S_WR_J: begin
                o_we    = 1'b1;
                o_waddr = r_j;
                o_wdata = r_val_i;
                n_state = r_last ? fyrs_pkg::S_EM_RD : fyrs_pkg::S_IDLE;
            end
            fyrs_pkg::S_EM_RD: begin
                o_re    = 1'b1;
                o_raddr = r_k;
                n_state = fyrs_pkg::S_EM_LD;
            end
            fyrs_pkg::S_EM_LD: begin
                if (load) begin
                    n_state = k_final ? fyrs_pkg::S_IDLE : fyrs_pkg::S_EM_RD;
                end
            end
            default: begin
                n_state = fyrs_pkg::S_IDLE;
            end
        endcase
    end

    // Step payload.
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_pos  <= i_q_pos;
            r_last <= i_q_last;
        end
        if (r_state == fyrs_pkg::S_DIV && i_div_done) begin
            r_j <= PW'(i_div_rem);
        end
        if (r_state == fyrs_pkg::S_RD_J) begin
            r_val_i <= rd_val;
        end
        if (o_re) begin
            r_raddr_q <= o_raddr;
        end
        if (r_state == fyrs_pkg::S_EM_LD && load) begin
            r_out_elem <= EW'(rd_val);
            r_out_last <= k_final;
        end
    end

    // Store valid bits, emission counter and output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld       <= '0;
            r_k         <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_restart) begin
                r_vld <= '0;
            end else if (o_we) begin
                r_vld[o_waddr] <= 1'b1;
            end else if (r_state == fyrs_pkg::S_EM_LD && load && k_final) begin
                r_vld <= '0;
            end

            if (r_state == fyrs_pkg::S_WR_J) begin
                r_k <= '0;
            end else if (r_state == fyrs_pkg::S_EM_LD && load) begin
                r_k <= r_k + PW'(1);
            end

            if (r_state == fyrs_pkg::S_EM_LD && load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_row_element = r_out_elem;
    assign o_last_of_row = r_out_last;

endmodule

`default_nettype wire
